>>> rtl/tesq_pkg.sv
package tesq_pkg;

    // Operation selector carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_DELETE   = 2'd1,
        FUNC_DISPATCH = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NONE      = 2'd3
    } status_t;

    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam int CODE_W  = 8;
    localparam int DATA_W  = 32;
    localparam int HAND_W  = 8;
    localparam int ID_W    = 32;

    localparam int IN_TDATA_W  = 168;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_TUSER_W = 2;

    // One queued event as held in a cell
    typedef struct packed {
        logic [TIME_W-1:0]  expiry;
        logic [DELAY_W-1:0] period;
        logic [CODE_W-1:0]  code;
        logic               periodic;
        logic [DATA_W-1:0]  data;
        logic [HAND_W-1:0]  handler;
        logic [ID_W-1:0]    ident;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2,
        CELL_CLEAR  = 2'd3
    } cell_op_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        cell_op_t       op;
        entry_t         ins;
        logic [ID_W-1:0] target;
    } cell_ctrl_t;

    // Expiry as time plus delay, saturated at the top of the time range
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] base,
                                                  input logic [DELAY_W-1:0] dly);
        logic [TIME_W:0] sum;
        sum = {1'b0, base} + {{(TIME_W + 1 - DELAY_W){1'b0}}, dly};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

>>> rtl/tesq_cell.sv
module tesq_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tesq_pkg::cell_ctrl_t      ctrl,
    input  logic                      shift_en,
    input  tesq_pkg::entry_t          prev_entry,
    input  logic                      prev_valid,
    input  logic                      prev_le,
    input  tesq_pkg::entry_t          next_entry,
    input  logic                      next_valid,
    output tesq_pkg::entry_t          entry,
    output logic                      valid,
    output logic                      le,
    output logic                      hit
);
    import tesq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    assign entry = entry_reg;
    assign valid = valid_reg;

    // Stay in place on insert when this event is due no later than the new one
    assign le  = valid_reg && (entry_reg.expiry <= ctrl.ins.expiry);
    assign hit = valid_reg && (entry_reg.ident == ctrl.target);

    // Select the next content: keep, take the new event, move one place, or clear
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (!le)
                begin
                    if (prev_le)
                    begin
                        entry_next = ctrl.ins;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        entry_next = prev_entry;
                        valid_next = prev_valid;
                    end
                end
            end
            CELL_SHIFT:
            begin
                if (shift_en)
                begin
                    entry_next = next_entry;
                    valid_next = next_valid;
                end
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/timed_event_scheduler_queue_unit.sv
// Time-ordered event queue held in a row of QUEUE_DEPTH cells, kept sorted by
// expiry with equal expiries in arrival order; cell 0 always holds the next
// event due. Each beat on the input carries one operation (insert, delete by
// id, dispatch, clear) and yields exactly one result beat. Every operation
// takes an accepting cycle, which registers the new event's expiry or the
// per-cell id compare, and then a finishing state, which updates all cells in
// parallel and loads the result; the finishing state waits while the output
// register is still full. A dispatch of a periodic event adds a re-arm insert
// state before the next beat is taken. A result waiting on the output does not
// stop the next beat being accepted; the row updates only once the output
// register is free. Times are unsigned fixed point with 16 fraction bits.
module timed_event_scheduler_queue_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // event_code[7:0], delay[39:8], is_periodic[40], data_handle[72:41],
    // handler_index[80:73], target_id[112:81], horizon[160:113], zero pad
    input  logic [tesq_pkg::IN_TDATA_W-1:0]       s_tdata,
    // func[1:0]
    input  logic [tesq_pkg::IN_TUSER_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // event_id[31:0], out_code[39:32], out_data_handle[71:40],
    // out_handler_index[79:72], now[127:80]
    output logic [tesq_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [tesq_pkg::OUT_TUSER_W-1:0]      m_tuser
);
    import tesq_pkg::*;

    localparam int N = QUEUE_DEPTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_POP,
        S_REARM,
        S_DONE
    } state_t;

    // Input fields
    logic [CODE_W-1:0]  in_code;
    logic [DELAY_W-1:0] in_delay;
    logic               in_periodic;
    logic [DATA_W-1:0]  in_data;
    logic [HAND_W-1:0]  in_handler;
    logic [ID_W-1:0]    in_target;
    logic [TIME_W-1:0]  in_horizon;
    func_t              in_func;

    assign in_code     = s_tdata[7:0];
    assign in_delay    = s_tdata[39:8];
    assign in_periodic = s_tdata[40];
    assign in_data     = s_tdata[72:41];
    assign in_handler  = s_tdata[80:73];
    assign in_target   = s_tdata[112:81];
    assign in_horizon  = s_tdata[160:113];
    assign in_func     = func_t'(s_tuser[1:0]);

    state_t             state_reg;
    func_t              op_reg;
    status_t            status_reg;
    entry_t             new_reg;
    logic [ID_W-1:0]    target_reg;
    logic [N-1:0]       match_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [ID_W-1:0]    ident_reg;
    logic               m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    status_t            m_status_reg;

    entry_t             cell_entry [N];
    logic [N-1:0]       cell_valid;
    logic [N-1:0]       cell_le;
    logic [N-1:0]       cell_hit;
    logic [N-1:0]       shift_mask;
    logic [N-1:0]       del_mask;
    logic               del_found;
    logic               can_emit;
    logic               out_load;
    cell_ctrl_t         ctrl;
    entry_t             head;
    logic               s_accept;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign can_emit = !m_tvalid_reg || m_tready;
    assign head     = cell_entry[0];

    // Load a result beat in the finishing state of each operation
    assign out_load = can_emit && ((state_reg == S_INS) || (state_reg == S_DEL) ||
                                   (state_reg == S_POP) || (state_reg == S_DONE));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_status_reg;

    // Cells at and above the earliest id match move down by one
    assign del_found = |match_reg;
    assign del_mask  = ~((match_reg - {{(N - 1){1'b0}}, 1'b1}) & ~match_reg);

    // Drive the row of cells from the sequencer state
    always_comb
    begin
        ctrl.op     = CELL_HOLD;
        ctrl.ins    = new_reg;
        ctrl.target = in_target;
        shift_mask  = '1;
        case (state_reg)
            S_INS:
            begin
                if (can_emit)
                begin
                    ctrl.op = CELL_INSERT;
                end
            end
            S_REARM:
            begin
                ctrl.op = CELL_INSERT;
            end
            S_DEL:
            begin
                shift_mask = del_mask;
                if (can_emit && del_found)
                begin
                    ctrl.op = CELL_SHIFT;
                end
            end
            S_POP:
            begin
                if (can_emit)
                begin
                    ctrl.op = CELL_SHIFT;
                end
            end
            S_DONE:
            begin
                if (can_emit && (op_reg == FUNC_CLEAR))
                begin
                    ctrl.op = CELL_CLEAR;
                end
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    // Row of cells, each linked to both neighbours
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        entry_t prev_e;
        logic   prev_v;
        logic   prev_l;
        entry_t next_e;
        logic   next_v;

        if (i == 0)
        begin : g_first
            assign prev_e = new_reg;
            assign prev_v = 1'b0;
            assign prev_l = 1'b1;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_v = cell_valid[i-1];
            assign prev_l = cell_le[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign next_e = cell_entry[i];
            assign next_v = 1'b0;
        end
        else
        begin : g_body
            assign next_e = cell_entry[i+1];
            assign next_v = cell_valid[i+1];
        end

        tesq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .shift_en   (shift_mask[i]),
            .prev_entry (prev_e),
            .prev_valid (prev_v),
            .prev_le    (prev_l),
            .next_entry (next_e),
            .next_valid (next_v),
            .entry      (cell_entry[i]),
            .valid      (cell_valid[i]),
            .le         (cell_le[i]),
            .hit        (cell_hit[i])
        );
    end

    // Sequencer with time, id counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= FUNC_INSERT;
            status_reg   <= STAT_OK;
            new_reg      <= '0;
            target_reg   <= '0;
            match_reg    <= '0;
            now_reg      <= '0;
            ident_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_status_reg <= STAT_OK;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        op_reg <= in_func;
                        case (in_func)
                            FUNC_INSERT:
                            begin
                                if (cell_valid[N-1])
                                begin
                                    status_reg <= STAT_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    new_reg <= '{expiry:   sat_add(now_reg, in_delay),
                                                 period:   in_delay,
                                                 code:     in_code,
                                                 periodic: in_periodic,
                                                 data:     in_data,
                                                 handler:  in_handler,
                                                 ident:    ident_reg};
                                    state_reg <= S_INS;
                                end
                            end
                            FUNC_DELETE:
                            begin
                                match_reg  <= cell_hit;
                                target_reg <= in_target;
                                state_reg  <= S_DEL;
                            end
                            FUNC_DISPATCH:
                            begin
                                if (!cell_valid[0] || (now_reg >= in_horizon))
                                begin
                                    status_reg <= STAT_NONE;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_POP;
                                end
                            end
                            default:
                            begin
                                status_reg <= STAT_OK;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INS:
                begin
                    if (can_emit)
                    begin
                        m_status_reg <= STAT_OK;
                        m_tdata_reg  <= {now_reg, {HAND_W{1'b0}}, {DATA_W{1'b0}},
                                         {CODE_W{1'b0}}, ident_reg};
                        ident_reg    <= ident_reg + 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_DEL:
                begin
                    if (can_emit)
                    begin
                        m_status_reg <= del_found ? STAT_OK : STAT_NOT_FOUND;
                        m_tdata_reg  <= {now_reg, {HAND_W{1'b0}}, {DATA_W{1'b0}},
                                         {CODE_W{1'b0}}, target_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                S_POP:
                begin
                    if (can_emit)
                    begin
                        now_reg      <= head.expiry;
                        m_status_reg <= STAT_OK;
                        m_tdata_reg  <= {head.expiry, head.handler, head.data,
                                         head.code, head.ident};
                        new_reg      <= '{expiry:   sat_add(head.expiry, head.period),
                                          period:   head.period,
                                          code:     head.code,
                                          periodic: 1'b1,
                                          data:     head.data,
                                          handler:  head.handler,
                                          ident:    head.ident};
                        state_reg    <= head.periodic ? S_REARM : S_IDLE;
                    end
                end
                S_REARM:
                begin
                    state_reg <= S_IDLE;
                end
                S_DONE:
                begin
                    if (can_emit)
                    begin
                        m_status_reg <= status_reg;
                        if (op_reg == FUNC_CLEAR)
                        begin
                            now_reg     <= '0;
                            m_tdata_reg <= '0;
                        end
                        else
                        begin
                            m_tdata_reg <= {now_reg, {(OUT_TDATA_W - TIME_W){1'b0}}};
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Occupied cells form an unbroken run from cell 0
    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + {{(N - 1){1'b0}}, 1'b1}) & cell_valid) == '0)
        else $error("queue cells not compact");

    // Head of the row is due no later than its neighbour
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_entry[0].expiry <= cell_entry[1].expiry))
        else $error("queue head out of order");

    // Dispatch never moves time backwards
    a_time_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) && can_emit |=> now_reg >= $past(now_reg))
        else $error("dispatch moved time backwards");
`endif

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tesq_pkg::*;

    localparam int SLOTS = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int BACKLOG_MAX = 4;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [TIME_W-1:0] TIME_LIMIT = '1;
    localparam logic [DELAY_W-1:0] ONE_UNIT = 32'h0001_0000;

    // One operation as offered on the input
    typedef struct {
        func_t              func;
        logic [CODE_W-1:0]  code;
        logic [DELAY_W-1:0] delay;
        logic               periodic;
        logic [DATA_W-1:0]  data;
        logic [HAND_W-1:0]  handler;
        logic [ID_W-1:0]    target;
        logic [TIME_W-1:0]  horizon;
    } sched_op_t;

    // One reply as seen on the output
    typedef struct {
        status_t            status;
        logic [ID_W-1:0]    event_id;
        logic [CODE_W-1:0]  code;
        logic [DATA_W-1:0]  data;
        logic [HAND_W-1:0]  handler;
        logic [TIME_W-1:0]  now;
    } sched_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [IN_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    // Shadow of the scheduler: pending events in service order, time, next id
    entry_t shadow_events[$];
    logic [TIME_W-1:0] sim_now = '0;
    logic [ID_W-1:0] next_id = '0;

    sched_op_t op_backlog[$];
    sched_op_t offered;
    sched_reply_t predicted_replies[$];
    sched_reply_t head_reply;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int stall_cycles = 0;
    int mismatch_count = 0;
    int issued = 0;

    timed_event_scheduler_queue_unit #(
        .QUEUE_DEPTH(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    // Expiry from a base time, clamped at the top of the time range
    function automatic logic [TIME_W-1:0] expiry_after(input logic [TIME_W-1:0] base,
                                                       input logic [DELAY_W-1:0] span);
        longint unsigned total;
        total = base;
        total = total + span;
        if (total > TIME_LIMIT)
            return TIME_LIMIT;
        return TIME_W'(total);
    endfunction

    // Slot an event in behind every event that expires no later
    function automatic void enqueue_event(input entry_t ev);
        int pos;
        pos = 0;
        while (pos < shadow_events.size() && shadow_events[pos].expiry <= ev.expiry)
            pos++;
        shadow_events.insert(pos, ev);
    endfunction

    // Apply one operation to the shadow and return the reply it yields
    function automatic sched_reply_t advance_schedule(input sched_op_t op);
        sched_reply_t res;
        entry_t ev;
        res.status = STAT_OK;
        res.event_id = '0;
        res.code = '0;
        res.data = '0;
        res.handler = '0;
        case (op.func)
            FUNC_INSERT:
            begin
                if (shadow_events.size() >= SLOTS)
                    res.status = STAT_FULL;
                else
                begin
                    ev.expiry = expiry_after(sim_now, op.delay);
                    ev.period = op.delay;
                    ev.code = op.code;
                    ev.periodic = op.periodic;
                    ev.data = op.data;
                    ev.handler = op.handler;
                    ev.ident = next_id;
                    next_id = next_id + 1'b1;
                    enqueue_event(ev);
                    res.event_id = ev.ident;
                end
            end
            FUNC_DELETE:
            begin
                res.event_id = op.target;
                res.status = STAT_NOT_FOUND;
                for (int k = 0; k < shadow_events.size(); k++)
                begin
                    if (shadow_events[k].ident == op.target)
                    begin
                        shadow_events.delete(k);
                        res.status = STAT_OK;
                        break;
                    end
                end
            end
            FUNC_DISPATCH:
            begin
                if (shadow_events.size() == 0 || sim_now >= op.horizon)
                    res.status = STAT_NONE;
                else
                begin
                    ev = shadow_events.pop_front();
                    sim_now = ev.expiry;
                    res.event_id = ev.ident;
                    res.code = ev.code;
                    res.data = ev.data;
                    res.handler = ev.handler;
                    // re-arm keeps the id and queues behind equal expiries
                    if (ev.periodic)
                    begin
                        ev.expiry = expiry_after(sim_now, ev.period);
                        enqueue_event(ev);
                    end
                end
            end
            default:
            begin
                shadow_events.delete();
                sim_now = '0;
            end
        endcase
        res.now = sim_now;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Driver: on each accepted beat predict its reply, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_replies.push_back(advance_schedule(offered));
            if (!s_tvalid || s_tready)
            begin
                if (op_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    offered = op_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'b0, offered.horizon, offered.target, offered.handler,
                                offered.data, offered.periodic, offered.delay,
                                offered.code};
                    s_tuser <= offered.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted down here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rx_hold_left <= 0;
        else if (rx_hold_req)
            rx_hold_left <= RX_HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Monitor: compare each reply beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("reply beat with nothing outstanding");
                    mismatch_count++;
                end
                else
                begin
                    head_reply = predicted_replies.pop_front();
                    check_field("status", head_reply.status, m_tuser);
                    check_field("event_id", head_reply.event_id, m_tdata[31:0]);
                    check_field("out_code", head_reply.code, m_tdata[39:32]);
                    check_field("out_data_handle", head_reply.data, m_tdata[71:40]);
                    check_field("out_handler_index", head_reply.handler, m_tdata[79:72]);
                    check_field("now", head_reply.now, m_tdata[127:80]);
                end
            end
            m_tready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: give up when no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic sched_op_t op_of(input func_t f, input logic [CODE_W-1:0] code,
                                        input logic [DELAY_W-1:0] delay,
                                        input logic periodic,
                                        input logic [DATA_W-1:0] data,
                                        input logic [HAND_W-1:0] handler,
                                        input logic [ID_W-1:0] target,
                                        input logic [TIME_W-1:0] horizon);
        sched_op_t op;
        op.func = f;
        op.code = code;
        op.delay = delay;
        op.periodic = periodic;
        op.data = data;
        op.handler = handler;
        op.target = target;
        op.horizon = horizon;
        return op;
    endfunction

    // Random operation; ties, live ids and horizons near now are favoured
    function automatic sched_op_t make_op(input func_t f);
        sched_op_t op;
        int pick;
        op.func = f;
        op.code = CODE_W'($urandom);
        op.periodic = ($urandom_range(0, 3) == 0);
        op.data = $urandom;
        op.handler = HAND_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            op.delay = '0;
        else if (pick <= 5)
            op.delay = $urandom_range(0, 15) << 12;
        else if (pick <= 7)
            op.delay = $urandom_range(0, 32'h000F_FFFF);
        else if (pick == 8)
            op.delay = $urandom;
        else
            op.delay = '1;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            op.horizon = TIME_LIMIT;
        else if (pick == 6)
            op.horizon = TIME_W'({$urandom, $urandom});
        else if (pick == 7)
            op.horizon = sim_now;
        else
            op.horizon = sim_now + $urandom_range(1, 32'h0004_0000);
        pick = $urandom_range(0, 9);
        if (pick <= 6 && shadow_events.size() != 0)
            op.target = shadow_events[$urandom_range(0, shadow_events.size() - 1)].ident;
        else if (pick <= 8)
            op.target = next_id - ID_W'($urandom_range(1, 4));
        else
            op.target = $urandom;
        return op;
    endfunction

    task automatic queue_op(input sched_op_t op);
        while (op_backlog.size() >= BACKLOG_MAX)
            @(negedge clk);
        op_backlog.push_back(op);
        issued++;
    endtask

    // Hold the sender until every predicted reply has been seen
    task automatic settle();
        while (op_backlog.size() != 0 || s_tvalid || predicted_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random(input int count);
        int goal;
        int pick;
        int n;
        sched_op_t op;
        goal = issued + count;
        while (issued < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                repeat ($urandom_range(1, 6)) queue_op(make_op(FUNC_INSERT));
            else if (pick < 50)
                repeat ($urandom_range(1, 6)) queue_op(make_op(FUNC_DISPATCH));
            else if (pick < 65)
                repeat ($urandom_range(1, 3)) queue_op(make_op(FUNC_DELETE));
            else if (pick < 72)
            begin
                // fill past capacity
                n = SLOTS - shadow_events.size() + $urandom_range(1, 3);
                repeat (n) queue_op(make_op(FUNC_INSERT));
            end
            else if (pick < 76)
            begin
                n = shadow_events.size() + 2;
                repeat (n)
                begin
                    op = make_op(FUNC_DISPATCH);
                    op.horizon = TIME_LIMIT;
                    queue_op(op);
                end
            end
            else if (pick < 79)
                queue_op(make_op(FUNC_CLEAR));
            else
                queue_op(make_op(func_t'($urandom_range(0, 3))));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty queue, field extremes, ties, re-arm, horizon, clear
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_DELETE, '0, '0, 1'b0, '0, '0, '1, TIME_LIMIT));
        queue_op(op_of(FUNC_INSERT, '0, '0, 1'b0, '0, '0, '0, '0));
        queue_op(op_of(FUNC_INSERT, '1, '1, 1'b1, '1, '1, '1, TIME_LIMIT));
        queue_op(op_of(FUNC_INSERT, 8'hA5, 5 * ONE_UNIT, 1'b1, 32'h1234, 8'h03, '0, '0));
        queue_op(op_of(FUNC_INSERT, 8'h5A, 5 * ONE_UNIT, 1'b0, 32'h5678, 8'h0C, '0, '0));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, '0));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_INSERT, 8'h77, '0, 1'b1, 32'h9ABC, 8'h40, '0, '0));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, 48'h5_0001));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, 48'h5_0000));
        queue_op(op_of(FUNC_DELETE, '0, '0, 1'b0, '0, '0, 32'd1, '0));
        queue_op(op_of(FUNC_DELETE, '0, '0, 1'b0, '0, '0, 32'd1, '0));
        queue_op(op_of(FUNC_DELETE, '0, '0, 1'b0, '0, '0, 32'd4, '0));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_CLEAR, '1, '1, 1'b1, '1, '1, '1, TIME_LIMIT));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_INSERT, 8'h11, 32'd3, 1'b0, 32'h0BAD, 8'h22, '0, '0));
        queue_op(op_of(FUNC_DELETE, '0, '0, 1'b0, '0, '0, 32'd2, '0));
        settle();

        // Random phases with shifting back-pressure
        tx_idle_pct = 32;
        rx_idle_pct = 54;
        run_random(400);
        settle();
        tx_idle_pct = 54;
        rx_idle_pct = 32;
        run_random(400);
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(100);
        @(negedge clk);
        rx_hold_req = 1'b1;
        @(negedge clk);
        rx_hold_req = 1'b0;
        run_random(300);
        settle();

        // Walk time forward in the longest periodic steps
        queue_op(op_of(FUNC_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0));
        queue_op(op_of(FUNC_INSERT, 8'hC3, '1, 1'b1, 32'hFEED_F00D, 8'h81, '0, '0));
        repeat (24) queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_INSERT, 8'h3C, 32'd5, 1'b0, 32'h0000_0001, 8'h18, '0, '0));
        queue_op(op_of(FUNC_INSERT, 8'h3D, '0, 1'b1, 32'h0000_0002, 8'h19, '0, '0));
        queue_op(op_of(FUNC_DISPATCH, '0, '0, 1'b0, '0, '0, '0, TIME_LIMIT));
        queue_op(op_of(FUNC_DELETE, '0, '0, 1'b0, '0, '0, next_id, '0));
        queue_op(op_of(FUNC_CLEAR, '0, '0, 1'b0, '0, '0, '0, '0));
        settle();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> timed_event_scheduler_queue_unit.f
rtl/tesq_pkg.sv
rtl/tesq_cell.sv
rtl/timed_event_scheduler_queue_unit.sv
sim/tb.sv
